[rtl/nmwsp_pkg.sv]
// ----------------------------------------------------------------------------
// nmwsp_pkg
// Character codes, result codes and fixed widths for the wind sentence parser.
// ----------------------------------------------------------------------------
package nmwsp_pkg;

    localparam int unsigned POS_W    = 6;
    localparam int unsigned TOKEN_W  = 3;
    localparam int unsigned ACC_W    = 17;
    localparam int unsigned DIR_W    = 11;
    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned PADDR_W  = 3;

    localparam logic [ACC_W-1:0]   ACC_CAP       = 17'd131071;
    localparam logic [ACC_W-1:0]   SPEED_CAP_POS = 17'd32767;
    localparam logic [ACC_W-1:0]   SPEED_CAP_NEG = 17'd32768;
    localparam logic [DIR_W-1:0]   DIR_CAP       = 11'd1023;
    // ceil(2^24 / 100): exact floor(x / 100) for any 17-bit x
    localparam logic [17:0]        RECIP_100     = 18'd167773;
    localparam int unsigned        RECIP_SHIFT   = 24;
    localparam logic [CFG_W-1:0]   TIMEOUT_RESET = 32'd10000;

    localparam logic [TOKEN_W-1:0] TOKEN_DIR     = 3'd1;
    localparam logic [TOKEN_W-1:0] TOKEN_SPEED   = 3'd3;
    localparam logic [TOKEN_W-1:0] TOKEN_LAST    = 3'd7;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic FUNC_BYTE       = 1'b0;
    localparam logic FUNC_TICK       = 1'b1;
    localparam logic STATUS_SENTENCE = 1'b0;
    localparam logic STATUS_TIMEOUT  = 1'b1;
    localparam logic REG_TIMEOUT     = 1'b0;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_BODY,
        PH_DONE
    } num_phase_t;

endpackage

[rtl/nmea_wind_sentence_parser.sv]
// ----------------------------------------------------------------------------
// nmea_wind_sentence_parser
// Parses MWV-style wind sentences from a byte stream and runs a tick watchdog.
// Each request is a received character or a millisecond tick. A sentence
// starts at '$' and ends at a newline or after MAX_SENTENCE_CHARS characters
// (the byte after a full sentence is dropped). Sentences whose second
// character is 'I' produce a result carrying the held direction (token 1,
// integer degrees, saturating at +-1023) and speed (token 3, hundredths,
// saturating to 16 bits signed). The watchdog produces a timeout result after
// timeout_ticks ticks without an accepted sentence. One request is taken every
// cycle; a request passes an input register and the parser state update, and
// its result, if any, goes into the result register as the request leaves
// the input register, and is presented from then on. A result still waiting
// on m_ready holds the request in the input register, so requests stall for
// as long as the result side stalls. Register timeout_ticks sits at byte
// address 0 of the APB port.
// ----------------------------------------------------------------------------
module nmea_wind_sentence_parser
    import nmwsp_pkg::*;
#(
    parameter int unsigned MAX_SENTENCE_CHARS = 49
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic [7:0]                s_rx_byte,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_status,
    output logic signed [DIR_W-1:0]   m_direction,
    output logic signed [SPEED_W-1:0] m_speed_hundredths,
    output logic                      m_direction_updated,
    output logic                      m_speed_updated,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [CFG_W-1:0]          pwdata,
    output logic [CFG_W-1:0]          prdata,
    output logic                      pready
);

    // input stage
    logic             in_valid_reg;
    logic             in_func_reg;
    logic [7:0]       in_byte_reg;
    logic             advance;

    // configuration
    logic [CFG_W-1:0] timeout_ticks_reg;

    // parser state
    logic               in_sentence_reg, in_sentence_next;
    logic               drop_next_reg, drop_next_next;
    logic [POS_W-1:0]   char_position_reg, char_position_next;
    logic               second_is_i_reg, second_is_i_next;
    logic [TOKEN_W-1:0] token_number_reg, token_number_next;
    logic               after_separator_reg, after_separator_next;
    logic               token_active_reg, token_active_next;
    logic               value_negative_reg, value_negative_next;
    logic               seen_point_reg, seen_point_next;
    logic [1:0]         fraction_digits_reg, fraction_digits_next;
    logic [ACC_W-1:0]   value_accum_reg, value_accum_next;
    num_phase_t         num_phase_reg, num_phase_next;
    logic               cur_speed_reg, cur_speed_next;
    logic               nul_seen_reg, nul_seen_next;
    logic signed [DIR_W-1:0]   pending_direction_reg, pending_direction_next;
    logic signed [SPEED_W-1:0] pending_speed_reg, pending_speed_next;
    logic [1:0]         pending_flags_reg, pending_flags_next;
    logic signed [DIR_W-1:0]   held_direction_reg, held_direction_next;
    logic signed [SPEED_W-1:0] held_speed_reg, held_speed_next;
    logic [CFG_W-1:0]   tick_count_reg, tick_count_next;

    // result register
    logic                      m_valid_reg;
    logic                      m_status_reg;
    logic signed [DIR_W-1:0]   m_direction_reg;
    logic signed [SPEED_W-1:0] m_speed_reg;
    logic [1:0]                m_flags_reg;

    // datapath temporaries
    logic [7:0]               ch;
    logic                     do_store;
    logic                     commit_req;
    logic                     end_req;
    logic                     emit;
    logic                     res_status;
    logic [3:0]               digit;
    logic [20:0]              int_sum;
    logic [17:0]              frac_sum;
    logic [34:0]              dir_product;
    logic [DIR_W-1:0]         dir_quot;
    logic [DIR_W-1:0]         dir_mag;
    logic signed [DIR_W-1:0]  commit_direction;
    logic [ACC_W-1:0]         speed_mag;
    logic signed [SPEED_W-1:0] commit_speed;

    logic cfg_write;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TIMEOUT) ? timeout_ticks_reg : '0;

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_direction         = m_direction_reg;
    assign m_speed_hundredths  = m_speed_reg;
    assign m_direction_updated = m_flags_reg[0];
    assign m_speed_updated     = m_flags_reg[1];

    assign ch = in_byte_reg;

    // token value as committed: taken from the registered accumulator
    assign dir_product = {18'd0, value_accum_reg} * {17'd0, RECIP_100};
    assign dir_quot    = dir_product[RECIP_SHIFT +: DIR_W];
    assign dir_mag     = (dir_quot > DIR_CAP) ? DIR_CAP : dir_quot;
    assign commit_direction = value_negative_reg ? -$signed(dir_mag) : $signed(dir_mag);

    always_comb begin
        if (value_negative_reg) begin
            speed_mag = (value_accum_reg > SPEED_CAP_NEG) ? SPEED_CAP_NEG : value_accum_reg;
        end else begin
            speed_mag = (value_accum_reg > SPEED_CAP_POS) ? SPEED_CAP_POS : value_accum_reg;
        end
    end
    assign commit_speed = value_negative_reg ? -$signed(speed_mag[SPEED_W-1:0])
                                             : $signed(speed_mag[SPEED_W-1:0]);

    always_comb begin
        in_sentence_next       = in_sentence_reg;
        drop_next_next         = drop_next_reg;
        char_position_next     = char_position_reg;
        second_is_i_next       = second_is_i_reg;
        token_number_next      = token_number_reg;
        after_separator_next   = after_separator_reg;
        token_active_next      = token_active_reg;
        value_negative_next    = value_negative_reg;
        seen_point_next        = seen_point_reg;
        fraction_digits_next   = fraction_digits_reg;
        value_accum_next       = value_accum_reg;
        num_phase_next         = num_phase_reg;
        cur_speed_next         = cur_speed_reg;
        nul_seen_next          = nul_seen_reg;
        pending_direction_next = pending_direction_reg;
        pending_speed_next     = pending_speed_reg;
        pending_flags_next     = pending_flags_reg;
        held_direction_next    = held_direction_reg;
        held_speed_next        = held_speed_reg;
        tick_count_next        = tick_count_reg;
        do_store   = 1'b0;
        commit_req = 1'b0;
        end_req    = 1'b0;
        emit       = 1'b0;
        res_status = STATUS_SENTENCE;
        digit      = ch[3:0];
        int_sum    = '0;
        frac_sum   = '0;

        if (in_func_reg == FUNC_TICK) begin
            tick_count_next = tick_count_reg + 32'd1;
            if (tick_count_next >= timeout_ticks_reg) begin
                tick_count_next = '0;
                emit            = 1'b1;
                res_status      = STATUS_TIMEOUT;
            end
        end else if (!in_sentence_reg) begin
            if (ch == CH_DOLLAR) begin
                in_sentence_next       = 1'b1;
                drop_next_next         = 1'b0;
                char_position_next     = '0;
                second_is_i_next       = 1'b0;
                token_number_next      = '0;
                after_separator_next   = 1'b1;
                token_active_next      = 1'b0;
                nul_seen_next          = 1'b0;
                pending_flags_next     = '0;
                pending_direction_next = '0;
                pending_speed_next     = '0;
                do_store               = 1'b1;
            end
        end else if (drop_next_reg || ch == CH_LF) begin
            commit_req       = 1'b1;
            end_req          = 1'b1;
            in_sentence_next = 1'b0;
            drop_next_next   = 1'b0;
        end else begin
            do_store = 1'b1;
        end

        if (do_store) begin
            if (!nul_seen_next) begin
                if (ch == CH_NUL) begin
                    commit_req    = 1'b1;
                    nul_seen_next = 1'b1;
                end else begin
                    if (char_position_next == POS_W'(1) && ch == CH_I) begin
                        second_is_i_next = 1'b1;
                    end
                    if (ch == CH_COMMA) begin
                        commit_req           = 1'b1;
                        after_separator_next = 1'b1;
                    end else begin
                        // first character of a new token
                        if (after_separator_next) begin
                            after_separator_next = 1'b0;
                            if (token_number_next == TOKEN_DIR ||
                                token_number_next == TOKEN_SPEED) begin
                                token_active_next    = 1'b1;
                                cur_speed_next       = (token_number_next == TOKEN_SPEED);
                                value_negative_next  = 1'b0;
                                seen_point_next      = 1'b0;
                                fraction_digits_next = '0;
                                value_accum_next     = '0;
                                num_phase_next       = PH_LEAD;
                            end
                            if (token_number_next != TOKEN_LAST) begin
                                token_number_next = token_number_next + TOKEN_W'(1);
                            end
                        end
                        if (token_active_next && num_phase_next != PH_DONE) begin
                            if (num_phase_next == PH_LEAD &&
                                (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))) begin
                                // skip leading blanks
                            end else if (num_phase_next == PH_LEAD &&
                                         (ch == CH_PLUS || ch == CH_MINUS)) begin
                                value_negative_next = (ch == CH_MINUS);
                                num_phase_next      = PH_BODY;
                            end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
                                num_phase_next = PH_BODY;
                                if (!seen_point_next) begin
                                    int_sum = {4'd0, value_accum_next} * 21'd10
                                            + {17'd0, digit} * 21'd100;
                                    value_accum_next = (int_sum > {4'd0, ACC_CAP}) ?
                                                       ACC_CAP : int_sum[ACC_W-1:0];
                                end else if (fraction_digits_next != 2'd2) begin
                                    if (fraction_digits_next == 2'd0) begin
                                        frac_sum = {1'b0, value_accum_next}
                                                 + {14'd0, digit} * 18'd10;
                                    end else begin
                                        frac_sum = {1'b0, value_accum_next} + {14'd0, digit};
                                    end
                                    fraction_digits_next = fraction_digits_next + 2'd1;
                                    value_accum_next = (frac_sum > {1'b0, ACC_CAP}) ?
                                                       ACC_CAP : frac_sum[ACC_W-1:0];
                                end
                            end else if (ch == CH_POINT && !seen_point_next) begin
                                seen_point_next = 1'b1;
                                num_phase_next  = PH_BODY;
                            end else begin
                                num_phase_next = PH_DONE;
                            end
                        end
                    end
                end
            end
            char_position_next = char_position_next + POS_W'(1);
            if (char_position_next >= POS_W'(MAX_SENTENCE_CHARS)) begin
                drop_next_next = 1'b1;
            end
        end

        if (commit_req && token_active_reg) begin
            if (cur_speed_reg) begin
                pending_speed_next    = commit_speed;
                pending_flags_next[1] = 1'b1;
            end else begin
                pending_direction_next = commit_direction;
                pending_flags_next[0]  = 1'b1;
            end
            token_active_next = 1'b0;
        end

        if (end_req && second_is_i_reg) begin
            if (pending_flags_next[0]) begin
                held_direction_next = pending_direction_next;
            end
            if (pending_flags_next[1]) begin
                held_speed_next = pending_speed_next;
            end
            tick_count_next = '0;
            emit            = 1'b1;
            res_status      = STATUS_SENTENCE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            timeout_ticks_reg     <= TIMEOUT_RESET;
            in_sentence_reg       <= 1'b0;
            drop_next_reg         <= 1'b0;
            char_position_reg     <= '0;
            second_is_i_reg       <= 1'b0;
            token_number_reg      <= '0;
            after_separator_reg   <= 1'b0;
            token_active_reg      <= 1'b0;
            value_negative_reg    <= 1'b0;
            seen_point_reg        <= 1'b0;
            fraction_digits_reg   <= '0;
            value_accum_reg       <= '0;
            num_phase_reg         <= PH_LEAD;
            cur_speed_reg         <= 1'b0;
            nul_seen_reg          <= 1'b0;
            pending_direction_reg <= '0;
            pending_speed_reg     <= '0;
            pending_flags_reg     <= '0;
            held_direction_reg    <= '0;
            held_speed_reg        <= '0;
            tick_count_reg        <= '0;
            m_valid_reg           <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == REG_TIMEOUT) begin
                timeout_ticks_reg <= pwdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                in_sentence_reg       <= in_sentence_next;
                drop_next_reg         <= drop_next_next;
                char_position_reg     <= char_position_next;
                second_is_i_reg       <= second_is_i_next;
                token_number_reg      <= token_number_next;
                after_separator_reg   <= after_separator_next;
                token_active_reg      <= token_active_next;
                value_negative_reg    <= value_negative_next;
                seen_point_reg        <= seen_point_next;
                fraction_digits_reg   <= fraction_digits_next;
                value_accum_reg       <= value_accum_next;
                num_phase_reg         <= num_phase_next;
                cur_speed_reg         <= cur_speed_next;
                nul_seen_reg          <= nul_seen_next;
                pending_direction_reg <= pending_direction_next;
                pending_speed_reg     <= pending_speed_next;
                pending_flags_reg     <= pending_flags_next;
                held_direction_reg    <= held_direction_next;
                held_speed_reg        <= held_speed_next;
                tick_count_reg        <= tick_count_next;
                // the result register is free here: load it or leave it empty
                m_valid_reg           <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_byte_reg <= s_rx_byte;
        end
        if (advance && emit) begin
            m_status_reg    <= res_status;
            m_direction_reg <= held_direction_next;
            m_speed_reg     <= held_speed_next;
            m_flags_reg     <= (res_status == STATUS_TIMEOUT) ? 2'b00 : pending_flags_next;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_timeout_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STATUS_TIMEOUT) |-> (m_flags_reg == 2'b00))
        else $error("timeout result carries update flags");

    a_drop_only_in_sentence: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_sentence_reg |-> !drop_next_reg)
        else $error("drop pending outside a sentence");

    a_sentence_clears_watchdog: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit && res_status == STATUS_SENTENCE) |=> (tick_count_reg == '0))
        else $error("accepted sentence did not clear the tick counter");

    a_position_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        char_position_reg <= POS_W'(MAX_SENTENCE_CHARS))
        else $error("character position beyond sentence limit");

    a_direction_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_direction_reg != $signed({1'b1, {(DIR_W-1){1'b0}}}))
        else $error("held direction outside +-1023");

endmodule
